>>> src/rgbnv12_pkg.sv
// Shared types and constants for the RGB to NV12 converter.
// No dependencies; imported by rgb_to_nv12_converter_top.
package rgbnv12_pkg;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int RESET_WIDTH  = 1920;
   localparam int RESET_HEIGHT = 1080;

   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam int LUMA_ADDR_W   = 24;
   localparam int CHROMA_ADDR_W = 25;

   localparam logic signed [17:0] LUMA_BIAS   = 18'sd16;
   localparam logic signed [17:0] CHROMA_BIAS = 18'sd128;
   localparam logic signed [17:0] ROUND_TERM  = 18'sd128;

   typedef struct packed {
      logic [7:0]               luma;
      logic [LUMA_ADDR_W-1:0]   luma_addr;
      logic                     chroma_valid;
      logic [7:0]               chroma_blue;
      logic [7:0]               chroma_red;
      logic [CHROMA_ADDR_W-1:0] chroma_addr;
      logic                     frame_last;
   } result_type;

endpackage

>>> src/rgb_to_nv12_converter_top.sv
// RGB to NV12 converter top level: BT.601 luma/chroma and plane addresses.
// Depends on rgbnv12_pkg for result type, register indexes and defaults.
//
// Usage:
//   req_ channel carries one RGB pixel per transfer in raster order.
//   rsp_ channel returns one result per pixel: luma with its Y-plane
//   address, and on even row/even column pixels Cb/Cr with the Cb address
//   in the interleaved UV plane (Cr at the next byte). rsp_frame_last
//   marks the final pixel of a frame.
//   csr_ port writes frame_width (index 0) or frame_height (index 1);
//   either write restarts the frame. Other indexes are ignored.
// Timing:
//   A req_ transfer is registered into the output stage. One pixel per cycle
//   is sustained while rsp_stall is low; the path is three constant
//   multiply-adds per component sum and the position counters.
//   A two-entry output stage (result register plus skid register) keeps
//   req_ open while one result waits; req_stall rises only when both hold.
// Reset:
//   Synchronous, active high. Frame size returns to 1920x1080, position to
//   the frame start, and both output entries are emptied.
module rgb_to_nv12_converter_top
   import rgbnv12_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_red,
   input  logic [7:0]               req_green,
   input  logic [7:0]               req_blue,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_luma,
   output logic [LUMA_ADDR_W-1:0]   rsp_luma_addr,
   output logic                     rsp_chroma_valid,
   output logic [7:0]               rsp_chroma_blue,
   output logic [7:0]               rsp_chroma_red,
   output logic [CHROMA_ADDR_W-1:0] rsp_chroma_addr,
   output logic                     rsp_frame_last,
   input  logic                     csr_write_en,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int WH = $clog2(MAX_HEIGHT + 1);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int PW = WW + WH;

   localparam int RESET_W_EFF = (RESET_WIDTH < 2) ? 2 :
                                (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
   localparam int RESET_H_EFF = (RESET_HEIGHT < 2) ? 2 :
                                (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;
   localparam logic [CHROMA_ADDR_W-1:0] RESET_PLANE =
      CHROMA_ADDR_W'(RESET_W_EFF * RESET_H_EFF);

   function automatic logic [WW-1:0] sat_width(input logic [CSR_DATA_W-1:0] v);
      logic [CSR_DATA_W:0] x;
      x = {1'b0, v};
      if (x < (CSR_DATA_W+1)'(2)) begin
         return WW'(2);
      end else if (x > (CSR_DATA_W+1)'(MAX_WIDTH)) begin
         return WW'(MAX_WIDTH);
      end
      return WW'(x);
   endfunction

   function automatic logic [WH-1:0] sat_height(input logic [CSR_DATA_W-1:0] v);
      logic [CSR_DATA_W:0] x;
      x = {1'b0, v};
      if (x < (CSR_DATA_W+1)'(2)) begin
         return WH'(2);
      end else if (x > (CSR_DATA_W+1)'(MAX_HEIGHT)) begin
         return WH'(MAX_HEIGHT);
      end
      return WH'(x);
   endfunction

   function automatic logic [7:0] shift_bias_clamp(input logic signed [17:0] s,
                                                   input logic signed [17:0] bias);
      logic signed [17:0] q;
      q = (s >>> 8) + bias;
      if (q < 18'sd0) begin
         return 8'd0;
      end else if (q > 18'sd255) begin
         return 8'd255;
      end
      return q[7:0];
   endfunction

   logic [WW-1:0]            eff_width_ff;
   logic [WH-1:0]            eff_height_ff;
   logic [CHROMA_ADDR_W-1:0] plane_base_ff;
   logic [CW-1:0]            column_pos_ff;
   logic [RW-1:0]            row_pos_ff;
   logic [LUMA_ADDR_W-1:0]   luma_offset_ff;
   logic [CHROMA_ADDR_W-1:0] chroma_rel_ff;

   logic                     out_valid_ff;
   logic                     skid_valid_ff;
   result_type               out_ff;
   result_type               skid_ff;

   logic                     accept;
   logic                     take;
   logic                     csr_hit;
   logic [WW-1:0]            width_sel;
   logic [WH-1:0]            height_sel;
   logic [PW-1:0]            plane_prod;
   logic                     row_end;
   logic                     last;
   logic                     cvalid;
   logic signed [17:0]       rs;
   logic signed [17:0]       gs;
   logic signed [17:0]       bs;
   logic signed [17:0]       y_sum;
   logic signed [17:0]       cb_sum;
   logic signed [17:0]       cr_sum;
   result_type               result_in;

   assign accept    = req_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;

   assign csr_hit = csr_write_en &&
                    ((csr_index == CSR_FRAME_WIDTH) || (csr_index == CSR_FRAME_HEIGHT));

   always_comb begin
      width_sel  = eff_width_ff;
      height_sel = eff_height_ff;
      unique case (csr_index)
         CSR_FRAME_WIDTH:  width_sel  = sat_width(csr_data);
         CSR_FRAME_HEIGHT: height_sel = sat_height(csr_data);
         default: ;
      endcase
      plane_prod = PW'(width_sel) * PW'(height_sel);
   end

   assign row_end = (WW'(column_pos_ff) + WW'(1)) >= eff_width_ff;
   assign last    = row_end && ((WH'(row_pos_ff) + WH'(1)) >= eff_height_ff);
   assign cvalid  = !row_pos_ff[0] && !column_pos_ff[0];

   assign rs = $signed({10'd0, req_red});
   assign gs = $signed({10'd0, req_green});
   assign bs = $signed({10'd0, req_blue});

   assign y_sum  = 18'sd66 * rs + 18'sd129 * gs + 18'sd25 * bs + ROUND_TERM;
   assign cb_sum = 18'sd112 * bs - 18'sd38 * rs - 18'sd74 * gs + ROUND_TERM;
   assign cr_sum = 18'sd112 * rs - 18'sd94 * gs - 18'sd18 * bs + ROUND_TERM;

   always_comb begin
      result_in              = '0;
      result_in.luma         = shift_bias_clamp(y_sum, LUMA_BIAS);
      result_in.luma_addr    = luma_offset_ff;
      result_in.chroma_valid = cvalid;
      result_in.frame_last   = last;
      if (cvalid) begin
         result_in.chroma_blue = shift_bias_clamp(cb_sum, CHROMA_BIAS);
         result_in.chroma_red  = shift_bias_clamp(cr_sum, CHROMA_BIAS);
         result_in.chroma_addr = plane_base_ff + chroma_rel_ff +
                                 CHROMA_ADDR_W'(column_pos_ff);
      end
   end

   // frame size and position
   always_ff @(posedge clock) begin
      if (reset) begin
         eff_width_ff   <= WW'(RESET_W_EFF);
         eff_height_ff  <= WH'(RESET_H_EFF);
         plane_base_ff  <= RESET_PLANE;
         column_pos_ff  <= '0;
         row_pos_ff     <= '0;
         luma_offset_ff <= '0;
         chroma_rel_ff  <= '0;
      end else if (csr_hit) begin
         eff_width_ff   <= width_sel;
         eff_height_ff  <= height_sel;
         plane_base_ff  <= CHROMA_ADDR_W'(plane_prod);
         column_pos_ff  <= '0;
         row_pos_ff     <= '0;
         luma_offset_ff <= '0;
         chroma_rel_ff  <= '0;
      end else if (accept) begin
         if (last) begin
            column_pos_ff  <= '0;
            row_pos_ff     <= '0;
            luma_offset_ff <= '0;
            chroma_rel_ff  <= '0;
         end else if (row_end) begin
            if (row_pos_ff[0]) begin
               chroma_rel_ff <= chroma_rel_ff + CHROMA_ADDR_W'(eff_width_ff);
            end
            column_pos_ff  <= '0;
            row_pos_ff     <= row_pos_ff + RW'(1);
            luma_offset_ff <= luma_offset_ff + LUMA_ADDR_W'(1);
         end else begin
            column_pos_ff  <= column_pos_ff + CW'(1);
            luma_offset_ff <= luma_offset_ff + LUMA_ADDR_W'(1);
         end
      end
   end

   // output register and skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         if (out_valid_ff && !take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (take) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (out_valid_ff && !take) begin
            skid_ff <= result_in;
         end else begin
            out_ff <= result_in;
         end
      end else if (take && skid_valid_ff) begin
         out_ff <= skid_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_luma         = out_ff.luma;
   assign rsp_luma_addr    = out_ff.luma_addr;
   assign rsp_chroma_valid = out_ff.chroma_valid;
   assign rsp_chroma_blue  = out_ff.chroma_blue;
   assign rsp_chroma_red   = out_ff.chroma_red;
   assign rsp_chroma_addr  = out_ff.chroma_addr;
   assign rsp_frame_last   = out_ff.frame_last;

endmodule
